/* sv/gs3_pkg.sv */
// ----------------------------------------------------------------------------
// gs3_pkg
// Shared types and constants of the 3x3 Gauss-Seidel solver.
// ----------------------------------------------------------------------------
package gs3_pkg;

  localparam int SWEEPS_DEF = 4;   // default number of sweeps
  localparam int N_VAR      = 3;   // unknowns, equations
  localparam int COEF_W     = 16;  // Q8.8
  localparam int X_W        = 32;  // Q16.16
  localparam int PROD_W     = COEF_W + X_W;      // Q8.8 * Q16.16
  localparam int NUM_W      = PROD_W + 1;        // numerator, signed
  localparam int MAG_W      = PROD_W;            // numerator magnitude
  localparam int DIV_STEPS  = 4;                 // quotient bits per stage
  localparam int DIV_STAGES = X_W / DIV_STEPS;   // stages per division
  localparam int UPD_LAT    = DIV_STAGES + 3;    // register stages per update

  // coef[var*3 + eq]: coefficient of x(var+1) in equation eq+1
  typedef struct packed {
    logic [N_VAR*N_VAR-1:0][COEF_W-1:0] coef;
    logic [N_VAR-1:0][COEF_W-1:0]       rhs;
    logic [N_VAR-1:0][X_W-1:0]          x;
    logic                               zp;
  } gs_item_t;

  typedef struct packed {
    logic [N_VAR-1:0][X_W-1:0] sol;
    logic                      zp;
  } gs_res_t;

endpackage

/* sv/gs3_if.sv */
// ----------------------------------------------------------------------------
// gs3_in_if / gs3_out_if
// Valid/ready channels for the system words and the solution words.
// ----------------------------------------------------------------------------
interface gs3_in_if import gs3_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [COEF_W-1:0] eq1_coef_x1, eq2_coef_x1, eq3_coef_x1;
  logic signed [COEF_W-1:0] eq1_coef_x2, eq2_coef_x2, eq3_coef_x2;
  logic signed [COEF_W-1:0] eq1_coef_x3, eq2_coef_x3, eq3_coef_x3;
  logic signed [COEF_W-1:0] rhs_eq1, rhs_eq2, rhs_eq3;

  modport source (
    output valid,
    output eq1_coef_x1, eq2_coef_x1, eq3_coef_x1,
    output eq1_coef_x2, eq2_coef_x2, eq3_coef_x2,
    output eq1_coef_x3, eq2_coef_x3, eq3_coef_x3,
    output rhs_eq1, rhs_eq2, rhs_eq3,
    input  ready
  );
  modport sink (
    input  valid,
    input  eq1_coef_x1, eq2_coef_x1, eq3_coef_x1,
    input  eq1_coef_x2, eq2_coef_x2, eq3_coef_x2,
    input  eq1_coef_x3, eq2_coef_x3, eq3_coef_x3,
    input  rhs_eq1, rhs_eq2, rhs_eq3,
    output ready
  );
endinterface

interface gs3_out_if import gs3_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] sol_x1, sol_x2, sol_x3;
  logic                  zero_pivot;

  modport source (
    output valid, sol_x1, sol_x2, sol_x3, zero_pivot,
    input  ready
  );
  modport sink (
    input  valid, sol_x1, sol_x2, sol_x3, zero_pivot,
    output ready
  );
endinterface

/* sv/gs3_upd.sv */
// ----------------------------------------------------------------------------
// gs3_upd
// One pipelined Gauss-Seidel update of unknown IDX: two products, numerator,
// radix-2 long division over DIV_STAGES stages, then sign and saturation.
// ----------------------------------------------------------------------------
module gs3_upd import gs3_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_vld,
  input  gs_item_t in_item,
  output logic     out_vld,
  output gs_item_t out_item
);

  localparam int J0 = (IDX == 0) ? 1 : 0;
  localparam int J1 = (IDX == 2) ? 1 : 2;
  localparam logic [X_W-1:0] POS_MAX = {1'b0, {(X_W-1){1'b1}}};
  localparam logic [X_W-1:0] NEG_MIN = {1'b1, {(X_W-1){1'b0}}};

  // ---- stage A: products
  logic                     a_vld_r;
  gs_item_t                 a_item_r;
  logic signed [PROD_W-1:0] a_pu_r, a_qw_r;
  logic signed [PROD_W-1:0] pu_nxt, qw_nxt;

  assign pu_nxt = $signed(in_item.coef[J0*N_VAR+IDX]) * $signed(in_item.x[J0]);
  assign qw_nxt = $signed(in_item.coef[J1*N_VAR+IDX]) * $signed(in_item.x[J1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item_r <= in_item;
      a_pu_r   <= pu_nxt;
      a_qw_r   <= qw_nxt;
    end
  end

  // ---- stage B: numerator, magnitudes, overflow precheck
  logic signed [NUM_W-1:0]  num;
  logic [COEF_W-1:0]        d, d_mag;
  logic [MAG_W-1:0]         n_mag;
  logic                     neg, ovf;

  always_comb begin
    num   = $signed({{(NUM_W-2*COEF_W){a_item_r.rhs[IDX][COEF_W-1]}},
                     a_item_r.rhs[IDX], {COEF_W{1'b0}}})
          - $signed({a_pu_r[PROD_W-1], a_pu_r})
          - $signed({a_qw_r[PROD_W-1], a_qw_r});
    d     = a_item_r.coef[IDX*N_VAR+IDX];
    d_mag = d[COEF_W-1] ? (~d + 1'b1) : d;
    n_mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    neg   = num[NUM_W-1] ^ d[COEF_W-1];
    // quotient of 2^32 or more can only saturate
    ovf   = n_mag[MAG_W-1:X_W] >= d_mag;
  end

  logic [DIV_STAGES:0] dv_vld_r;
  gs_item_t            dv_item_r [DIV_STAGES+1];
  logic [COEF_W-1:0]   dv_rem_r  [DIV_STAGES+1];
  logic [X_W-1:0]      dv_sh_r   [DIV_STAGES+1];  // dividend bits out, quotient in
  logic [COEF_W-1:0]   dv_dmag_r [DIV_STAGES+1];
  logic                dv_neg_r  [DIV_STAGES+1];
  logic                dv_ovf_r  [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_item_r[0] <= a_item_r;
      dv_rem_r[0]  <= n_mag[MAG_W-1:X_W];
      dv_sh_r[0]   <= n_mag[X_W-1:0];
      dv_dmag_r[0] <= d_mag;
      dv_neg_r[0]  <= neg;
      dv_ovf_r[0]  <= ovf;
    end
  end

  // ---- division stages
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [COEF_W-1:0] rem_nxt;
    logic [X_W-1:0]    sh_nxt;

    always_comb begin : p_steps
      logic [COEF_W:0] t;
      rem_nxt = dv_rem_r[s];
      sh_nxt  = dv_sh_r[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        t      = {rem_nxt, sh_nxt[X_W-1]};
        sh_nxt = {sh_nxt[X_W-2:0], 1'b0};
        if (t >= {1'b0, dv_dmag_r[s]}) begin
          rem_nxt   = COEF_W'(t - {1'b0, dv_dmag_r[s]});
          sh_nxt[0] = 1'b1;
        end else begin
          rem_nxt = t[COEF_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[s+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[s+1] <= dv_vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_item_r[s+1] <= dv_item_r[s];
        dv_rem_r[s+1]  <= rem_nxt;
        dv_sh_r[s+1]   <= sh_nxt;
        dv_dmag_r[s+1] <= dv_dmag_r[s];
        dv_neg_r[s+1]  <= dv_neg_r[s];
        dv_ovf_r[s+1]  <= dv_ovf_r[s];
      end
    end
  end

  // ---- stage C: sign and saturation
  logic [X_W-1:0] q, x_new;
  gs_item_t       item_nxt;
  logic           c_vld_r;
  gs_item_t       c_item_r;

  always_comb begin
    q = dv_sh_r[DIV_STAGES];
    if (!dv_neg_r[DIV_STAGES]) begin
      x_new = (dv_ovf_r[DIV_STAGES] || q > POS_MAX) ? POS_MAX : q;
    end else begin
      x_new = (dv_ovf_r[DIV_STAGES] || q > NEG_MIN) ? NEG_MIN : (~q + 1'b1);
    end
    item_nxt        = dv_item_r[DIV_STAGES];
    item_nxt.x[IDX] = x_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= dv_vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_item_r <= item_nxt;
    end
  end

  assign out_vld  = c_vld_r;
  assign out_item = c_item_r;

endmodule

/* sv/gs3_skid.sv */
// ----------------------------------------------------------------------------
// gs3_skid
// Output register plus skid entry; stalls the pipeline only when both hold
// a word.
// ----------------------------------------------------------------------------
module gs3_skid import gs3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_vld,
  input  gs_res_t in_res,
  output logic    en,
  input  logic    out_ready,
  output logic    out_vld,
  output gs_res_t out_res
);

  logic    out_vld_r, out_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  gs_res_t out_res_r, out_res_nxt;
  gs_res_t skid_res_r, skid_res_nxt;
  logic    push;

  assign en   = !skid_vld_r;
  assign push = in_vld && en;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (out_vld_r && out_ready) begin
      out_vld_nxt = skid_vld_r;
      out_res_nxt = skid_res_r;
      skid_vld_nxt = 1'b0;
    end
    if (push) begin
      if (out_vld_r && !out_ready) begin
        skid_vld_nxt = 1'b1;
        skid_res_nxt = in_res;
      end else begin
        out_vld_nxt = 1'b1;
        out_res_nxt = in_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_vld = out_vld_r;
  assign out_res = out_res_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid word held with empty output register");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_ready && in_vld))
    else $error("skid filled without a stalled output");

endmodule

/* sv/gauss_seidel_3x3_solver.sv */
// ----------------------------------------------------------------------------
// gauss_seidel_3x3_solver
// Fixed-sweep Gauss-Seidel solver for 3x3 systems, Q8.8 in, Q16.16 out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one system per word: nine Q8.8 coefficients and three
//   right-hand sides. out_ch returns one word per system: x1..x3 in
//   saturating Q16.16 after SWEEPS sweeps, and zero_pivot, which forces the
//   solution to zero when a diagonal coefficient is zero.
//   Each of the 3*SWEEPS updates is an 11-stage pipeline (product, numerator,
//   8 long-division stages of 4 quotient bits, saturation); the result then
//   passes the output register of gs3_skid.
//   Throughput is one word per cycle while unstalled; words stay in order.
//   When out_ch.ready is low, a skid entry takes one more word, then
//   in_ch.ready drops and the whole pipeline holds until the receiver takes
//   the waiting word.
//   Reset (rst_n low, synchronous) empties the pipeline and output; no
//   state carries from one word to the next.
// ----------------------------------------------------------------------------
module gauss_seidel_3x3_solver import gs3_pkg::*; #(
  parameter int SWEEPS = SWEEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gs3_in_if.sink    in_ch,
  gs3_out_if.source out_ch
);

  localparam int N_UPD = N_VAR * SWEEPS;

  logic     en;
  gs_item_t entry;

  always_comb begin
    entry.coef[0] = in_ch.eq1_coef_x1;
    entry.coef[1] = in_ch.eq2_coef_x1;
    entry.coef[2] = in_ch.eq3_coef_x1;
    entry.coef[3] = in_ch.eq1_coef_x2;
    entry.coef[4] = in_ch.eq2_coef_x2;
    entry.coef[5] = in_ch.eq3_coef_x2;
    entry.coef[6] = in_ch.eq1_coef_x3;
    entry.coef[7] = in_ch.eq2_coef_x3;
    entry.coef[8] = in_ch.eq3_coef_x3;
    entry.rhs[0]  = in_ch.rhs_eq1;
    entry.rhs[1]  = in_ch.rhs_eq2;
    entry.rhs[2]  = in_ch.rhs_eq3;
    entry.x       = '0;
    entry.zp      = (in_ch.eq1_coef_x1 == '0) || (in_ch.eq2_coef_x2 == '0)
                 || (in_ch.eq3_coef_x3 == '0);
  end

  logic [N_UPD:0] ch_vld;
  gs_item_t       ch_item [N_UPD+1];

  assign ch_vld[0]  = in_ch.valid;
  assign ch_item[0] = entry;

  for (genvar u = 0; u < N_UPD; u++) begin : g_upd
    gs3_upd #(.IDX(u % N_VAR)) u_upd (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (ch_vld[u]),
      .in_item  (ch_item[u]),
      .out_vld  (ch_vld[u+1]),
      .out_item (ch_item[u+1])
    );
  end

  gs_res_t res, out_res;
  logic    out_vld;

  always_comb begin
    res.zp  = ch_item[N_UPD].zp;
    res.sol = ch_item[N_UPD].zp ? '0 : ch_item[N_UPD].x;
  end

  gs3_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (ch_vld[N_UPD]),
    .in_res    (res),
    .en        (en),
    .out_ready (out_ch.ready),
    .out_vld   (out_vld),
    .out_res   (out_res)
  );

  assign in_ch.ready       = en;
  assign out_ch.valid      = out_vld;
  assign out_ch.sol_x1     = out_res.sol[0];
  assign out_ch.sol_x2     = out_res.sol[1];
  assign out_ch.sol_x3     = out_res.sol[2];
  assign out_ch.zero_pivot = out_res.zp;

  a_zp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && out_res.zp) |-> (out_res.sol == '0))
    else $error("zero pivot word with nonzero solution");

  // input valid is free to rise while stalled; only the stage bits must hold
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ch_vld[N_UPD:1]))
    else $error("pipeline moved while stalled");

endmodule
